// ----- src/name_value_command_parser_defines.svh -----
// Assertion macros for the name/value command parser checker.
// Stand-alone header, no dependencies.
`ifndef NAME_VALUE_COMMAND_PARSER_DEFINES_SVH
`define NAME_VALUE_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define NVCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define NVCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/nvcp_pkg.sv -----
// Shared types, character codes, register indexes and the fraction weight
// table for the name/value command parser. No dependencies.
package nvcp_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_0     = 3'd1;

   // Characters the parser reacts to
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_EQUALS = 8'h3D;

   // Integer part saturates at 2^31-1
   localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;
   // Fraction digit position where the weight has reached zero
   localparam logic [3:0] FRAC_POS_LAST = 4'd9;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic              matched;
      logic [1:0]        match_index;
      logic signed [47:0] parsed_value;
   } rsp_type;

   // Q0.32 weight of a fraction digit: 0.1 floor-divided by 10 per position
   function automatic logic [31:0] frac_weight(input logic [3:0] pos);
      logic [31:0] w;
      case (pos)
         4'd0:    w = 32'd429496730;
         4'd1:    w = 32'd42949673;
         4'd2:    w = 32'd4294967;
         4'd3:    w = 32'd429496;
         4'd4:    w = 32'd42949;
         4'd5:    w = 32'd4294;
         4'd6:    w = 32'd429;
         4'd7:    w = 32'd42;
         4'd8:    w = 32'd4;
         default: w = 32'd0;
      endcase
      return w;
   endfunction

endpackage

// ----- src/name_value_command_parser.sv -----
// Name/value command parser: the last byte of a message passes the input register, then
// its result is loaded into the result register; one byte per cycle sustained while no
// last byte waits on a full result register that is not being read. Other bytes give
// no result. Synchronous active-high reset clears message state, pipeline valids and
// the configuration registers (name count and names read as zero).
// Depends on nvcp_pkg.
module name_value_command_parser #(
   parameter int NUM_NAMES  = 4,
   parameter int NAME_CHARS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  nvcp_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output nvcp_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nvcp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                        csr_wdata
);

   localparam int NAME_W = 8 * NAME_CHARS;
   localparam int LEN_W  = $clog2(NAME_CHARS + 1);

   // Parse phase codes
   localparam logic [1:0] PH_NAME   = 2'd0;
   localparam logic [1:0] PH_VALUE  = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;
   localparam logic [1:0] PH_REJECT = 2'd3;

   // Configuration
   logic [2:0]  name_count_ff;
   logic [63:0] names_ff [NUM_NAMES];

   // Input register
   logic              in_valid_ff;
   nvcp_pkg::req_type in_data_ff;

   // Message state and its next values
   logic [1:0]        phase_ff, phase_in;
   logic [NAME_W-1:0] name_buf_ff, name_buf_in;
   logic [LEN_W-1:0]  name_len_ff, name_len_in;
   logic              first_ff, first_in;
   logic              neg_ff, neg_in;
   logic              frac_mode_ff, frac_mode_in;
   logic              stopped_ff, stopped_in;
   logic [30:0]       int_ff, int_in;
   logic [31:0]       frac_ff, frac_in;
   logic [3:0]        frac_pos_ff, frac_pos_in;

   // Result register
   logic              rsp_valid_ff;
   nvcp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic       advance;
   logic [7:0] ch;
   logic       is_digit;
   logic [3:0] digit;
   logic [34:0] int_ext, int_sum;
   logic [35:0] frac_prod;
   logic [36:0] frac_sum;

   assign ch       = in_data_ff.rx_byte;
   assign is_digit = (ch >= nvcp_pkg::CH_ZERO) && (ch <= nvcp_pkg::CH_NINE);
   assign digit    = ch[3:0];

   // Held item moves on unless it is a last byte facing a full result register not being read
   assign advance   = in_valid_ff
                      && (!in_data_ff.end_of_message || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Digit arithmetic: integer times ten plus digit, fraction plus weighted digit
   assign int_ext   = {4'd0, int_ff};
   assign int_sum   = (int_ext << 3) + (int_ext << 1) + 35'(digit);
   assign frac_prod = 36'(digit) * 36'(nvcp_pkg::frac_weight(frac_pos_ff));
   assign frac_sum  = 37'(frac_ff) + 37'(frac_prod);

   // Per-byte state update
   always_comb begin
      logic take_char;
      phase_in     = phase_ff;
      name_buf_in  = name_buf_ff;
      name_len_in  = name_len_ff;
      first_in     = first_ff;
      neg_in       = neg_ff;
      frac_mode_in = frac_mode_ff;
      stopped_in   = stopped_ff;
      int_in       = int_ff;
      frac_in      = frac_ff;
      frac_pos_in  = frac_pos_ff;
      take_char    = 1'b0;
      case (phase_ff)
         PH_NAME: begin
            if (ch == nvcp_pkg::CH_EQUALS) begin
               phase_in = PH_VALUE;
            end else if (ch == nvcp_pkg::CH_NUL) begin
               phase_in = PH_REJECT;
            end else if (32'(name_len_ff) < NAME_CHARS) begin
               for (int k = 0; k < NAME_CHARS; k++) begin
                  if (32'(name_len_ff) == k) begin
                     name_buf_in[8*k +: 8] = ch;
                  end
               end
               name_len_in = name_len_ff + LEN_W'(1);
            end
         end
         PH_VALUE: begin
            if (ch == nvcp_pkg::CH_HASH || ch == nvcp_pkg::CH_NUL) begin
               phase_in = PH_DONE;
            end else if (first_ff) begin
               first_in = 1'b0;
               if (ch == nvcp_pkg::CH_MINUS) begin
                  neg_in = 1'b1;
               end else if (ch != nvcp_pkg::CH_PLUS) begin
                  take_char = 1'b1;
               end
            end else begin
               take_char = 1'b1;
            end
         end
         default: begin
         end
      endcase
      // Value character: point, digit or stop
      if (take_char && !stopped_ff) begin
         if (ch == nvcp_pkg::CH_POINT) begin
            frac_mode_in = 1'b1;
         end else if (!is_digit) begin
            stopped_in = 1'b1;
         end else if (!frac_mode_ff) begin
            int_in = (int_sum > 35'(nvcp_pkg::INT_MAX)) ? nvcp_pkg::INT_MAX : int_sum[30:0];
         end else begin
            frac_in = (frac_sum[36:32] != 5'd0) ? 32'hFFFF_FFFF : frac_sum[31:0];
            if (frac_pos_ff != nvcp_pkg::FRAC_POS_LAST) begin
               frac_pos_in = frac_pos_ff + 4'd1;
            end
         end
      end
   end

   // Name compare on the updated buffer, first valid match wins
   always_comb begin
      logic [NAME_W-1:0] eff;
      logic              keep;
      logic              hit;
      logic [1:0]        idx;
      logic [47:0]       mag;
      hit = 1'b0;
      idx = 2'd0;
      for (int i = 0; i < NUM_NAMES; i++) begin
         keep = 1'b1;
         for (int k = 0; k < NAME_CHARS; k++) begin
            keep = keep && (names_ff[i][8*k +: 8] != 8'd0);
            eff[8*k +: 8] = keep ? names_ff[i][8*k +: 8] : 8'd0;
         end
         if (!hit && (32'(name_count_ff) > i) && (eff == name_buf_in)) begin
            hit = 1'b1;
            idx = 2'(i);
         end
      end
      if (phase_in != PH_VALUE && phase_in != PH_DONE) begin
         hit = 1'b0;
         idx = 2'd0;
      end
      mag = {1'b0, int_in, frac_in[31:16]};
      rsp_data_in.matched      = hit;
      rsp_data_in.match_index  = idx;
      if (!hit) begin
         rsp_data_in.parsed_value = '0;
      end else if (neg_in) begin
         rsp_data_in.parsed_value = -$signed(mag);
      end else begin
         rsp_data_in.parsed_value = $signed(mag);
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         name_count_ff <= 3'd0;
         for (int i = 0; i < NUM_NAMES; i++) begin
            names_ff[i] <= 64'd0;
         end
      end else if (csr_valid) begin
         if (csr_index == nvcp_pkg::CSR_NAME_COUNT) begin
            name_count_ff <= csr_wdata[2:0];
         end
         for (int i = 0; i < NUM_NAMES; i++) begin
            if (32'(csr_index) == 32'(nvcp_pkg::CSR_NAME_0) + i) begin
               names_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Message state: update per byte, clear after the last byte
   always_ff @(posedge clock) begin
      if (reset || (advance && in_data_ff.end_of_message)) begin
         phase_ff     <= PH_NAME;
         name_buf_ff  <= '0;
         name_len_ff  <= '0;
         first_ff     <= 1'b1;
         neg_ff       <= 1'b0;
         frac_mode_ff <= 1'b0;
         stopped_ff   <= 1'b0;
         int_ff       <= '0;
         frac_ff      <= '0;
         frac_pos_ff  <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         name_buf_ff  <= name_buf_in;
         name_len_ff  <= name_len_in;
         first_ff     <= first_in;
         neg_ff       <= neg_in;
         frac_mode_ff <= frac_mode_in;
         stopped_ff   <= stopped_in;
         int_ff       <= int_in;
         frac_ff      <= frac_in;
         frac_pos_ff  <= frac_pos_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_data_ff.end_of_message) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_data_ff.end_of_message) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- src/nvcp_checker.sv -----
// Port-level checks for the name/value command parser, bound to the top.
// Depends on nvcp_pkg and name_value_command_parser_defines.svh.
`include "name_value_command_parser_defines.svh"

module nvcp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input nvcp_pkg::rsp_type rsp_data
);

   // A stalled result holds
   `NVCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // An unmatched result carries index and value zero
   `NVCP_ASSERT_NOW(a_unmatched_zero, clock, reset, rsp_valid && !rsp_data.matched, rsp_data.match_index == 2'd0 && rsp_data.parsed_value == 48'sd0, "unmatched result not zero")

   // Input stalls only behind a stalled result
   `NVCP_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready, "input stalled without output backpressure")

   // No result right after reset
   `NVCP_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "result valid after reset")

endmodule

bind name_value_command_parser nvcp_checker u_nvcp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- test/name_value_command_parser_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for name_value_command_parser: a directed script, then random
// messages under random name settings and random stalls, all checked item by item.
// Depends on nvcp_pkg and the parser RTL.
module testbench;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int PHASE_BYTES   = 170;
   localparam int RANDOM_PHASES = 5;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int NAME_SLOTS    = 4;
   localparam logic [nvcp_pkg::CSR_INDEX_W-1:0] CSR_NAME_LAST = nvcp_pkg::CSR_NAME_0 + 3'd3;
   localparam logic [nvcp_pkg::CSR_INDEX_W-1:0] CSR_SPARE     = CSR_NAME_LAST + 3'd1;
   localparam logic [nvcp_pkg::CSR_INDEX_W-1:0] CSR_INDEX_TOP = {nvcp_pkg::CSR_INDEX_W{1'b1}};
   localparam logic [31:0] TENTH_Q32 = 32'd429496730;
   // Script text markers for bytes that a string cannot hold
   localparam logic [7:0] MARK_NUL  = "~";
   localparam logic [7:0] MARK_ONES = "^";

   typedef enum logic [1:0] {PH_NAME, PH_VALUE, PH_DONE, PH_REJECT} parse_phase_type;
   typedef enum logic {ROW_MSG, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                       kind;
      logic                               typed;
      logic [nvcp_pkg::CSR_INDEX_W-1:0]   csr_index;
      logic [63:0]                        csr_data;
      nvcp_pkg::rsp_type                  reply;
   } script_row_type;

   // DUT ports
   logic                             clock;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   nvcp_pkg::req_type                req_data  = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   nvcp_pkg::rsp_type                rsp_data;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [nvcp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]                      csr_wdata = '0;

   // Predicted configuration
   logic [2:0]   cfg_count;
   logic [63:0]  cfg_names [NAME_SLOTS];

   // Predicted message state
   parse_phase_type phase;
   logic [63:0]  name_buf;
   int           name_len;
   bit           first_char;
   bit           negative;
   bit           in_frac;
   bit           digits_stopped;
   logic [30:0]  int_part;
   logic [31:0]  frac_part;
   logic [31:0]  frac_weight;

   nvcp_pkg::rsp_type predicted_results[$];
   logic [7:0]        msg_bytes[$];
   script_row_type    script[$];
   string             script_text[$];
   int           errors     = 0;
   int           cycles     = 0;
   int           bytes_sent = 0;
   bit           sender_calm  = 1'b0;
   bit           hold_request = 1'b0;

   name_value_command_parser uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Name as compared: bytes up to the first zero byte
   function automatic logic [63:0] effective_name(input logic [63:0] raw);
      logic [63:0] eff;
      bit          ended;
      eff   = '0;
      ended = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (raw[8*i +: 8] == nvcp_pkg::CH_NUL) ended = 1'b1;
         if (!ended) eff[8*i +: 8] = raw[8*i +: 8];
      end
      return eff;
   endfunction

   function automatic void clear_message();
      phase          = PH_NAME;
      name_buf       = '0;
      name_len       = 0;
      first_char     = 1'b1;
      negative       = 1'b0;
      in_frac        = 1'b0;
      digits_stopped = 1'b0;
      int_part       = '0;
      frac_part      = '0;
      frac_weight    = TENTH_Q32;
   endfunction

   function automatic void apply_csr(input logic [nvcp_pkg::CSR_INDEX_W-1:0] idx,
                                     input logic [63:0] data);
      if (idx == nvcp_pkg::CSR_NAME_COUNT) cfg_count = data[2:0];
      else if (idx <= CSR_NAME_LAST) cfg_names[idx - nvcp_pkg::CSR_NAME_0] = data;
   endfunction

   // Digit accumulation: integer saturates at INT_MAX, fraction at all ones
   function automatic void add_value_char(input logic [7:0] ch);
      logic [34:0] acc;
      logic [35:0] sum;
      logic [3:0]  d;
      if (digits_stopped) return;
      if (ch == nvcp_pkg::CH_POINT) begin
         in_frac = 1'b1;
         return;
      end
      if (ch < nvcp_pkg::CH_ZERO || ch > nvcp_pkg::CH_NINE) begin
         digits_stopped = 1'b1;
         return;
      end
      d = 4'(ch - nvcp_pkg::CH_ZERO);
      if (!in_frac) begin
         acc      = 35'(int_part) * 35'd10 + 35'(d);
         int_part = (acc > 35'(nvcp_pkg::INT_MAX)) ? nvcp_pkg::INT_MAX : acc[30:0];
      end else begin
         sum         = 36'(frac_part) + 36'(d) * 36'(frac_weight);
         frac_part   = (sum > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
         frac_weight = frac_weight / 32'd10;
      end
   endfunction

   // Advance the parse by one byte; returns 1 with the result on the last byte
   function automatic bit advance_parse(input nvcp_pkg::req_type item,
                                        output nvcp_pkg::rsp_type res);
      logic [7:0]  ch;
      logic [46:0] mag;
      logic [2:0]  live;
      bit          hit;
      logic [1:0]  idx;
      ch  = item.rx_byte;
      res = '0;
      case (phase)
         PH_NAME: begin
            if (ch == nvcp_pkg::CH_EQUALS) phase = PH_VALUE;
            else if (ch == nvcp_pkg::CH_NUL) phase = PH_REJECT;
            else if (name_len < 8) begin
               name_buf[8*name_len +: 8] = ch;
               name_len++;
            end
         end
         PH_VALUE: begin
            if (ch == nvcp_pkg::CH_HASH || ch == nvcp_pkg::CH_NUL) phase = PH_DONE;
            else if (first_char) begin
               first_char = 1'b0;
               if (ch == nvcp_pkg::CH_MINUS) negative = 1'b1;
               else if (ch != nvcp_pkg::CH_PLUS) add_value_char(ch);
            end else add_value_char(ch);
         end
         default: ;
      endcase
      if (!item.end_of_message) return 1'b0;

      hit  = 1'b0;
      idx  = '0;
      live = (cfg_count > 3'(NAME_SLOTS)) ? 3'(NAME_SLOTS) : cfg_count;
      if (phase == PH_VALUE || phase == PH_DONE) begin
         for (int i = 0; i < NAME_SLOTS; i++) begin
            if (!hit && i < live && effective_name(cfg_names[i]) == name_buf) begin
               hit = 1'b1;
               idx = 2'(i);
            end
         end
      end
      mag              = {int_part, frac_part[31:16]};
      res.matched      = hit;
      res.match_index  = idx;
      res.parsed_value = '0;
      if (hit) res.parsed_value = negative ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      clear_message();
      return 1'b1;
   endfunction

   // Mostly no gap, sometimes short, rarely long
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] pack_name(input string s);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
      return v;
   endfunction

   function automatic logic [63:0] random_name();
      logic [63:0] v;
      int          n;
      if ($urandom_range(0, 9) < 3) return {$urandom, $urandom};
      v = '0;
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) v[8*i +: 8] = 8'($urandom_range(33, 126));
      // junk behind the terminator is ignored by the compare
      if (n < 7 && $urandom_range(0, 4) == 0) v[63:56] = 8'($urandom_range(1, 255));
      return v;
   endfunction

   function automatic void add_msg(input string t);
      script_row_type row;
      row      = '0;
      row.kind = ROW_MSG;
      script.push_back(row);
      script_text.push_back(t);
   endfunction

   function automatic void add_checked(input string t, input logic m, input logic [1:0] idx,
                                       input logic signed [47:0] v);
      script_row_type row;
      row                    = '0;
      row.kind               = ROW_MSG;
      row.typed              = 1'b1;
      row.reply.matched      = m;
      row.reply.match_index  = idx;
      row.reply.parsed_value = v;
      script.push_back(row);
      script_text.push_back(t);
   endfunction

   function automatic void add_csr(input logic [nvcp_pkg::CSR_INDEX_W-1:0] idx,
                                   input logic [63:0] data);
      script_row_type row;
      row           = '0;
      row.kind      = ROW_CSR;
      row.csr_index = idx;
      row.csr_data  = data;
      script.push_back(row);
      script_text.push_back("");
   endfunction

   function automatic void load_text(input string s);
      logic [7:0] c;
      msg_bytes.delete();
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c == MARK_NUL) msg_bytes.push_back(nvcp_pkg::CH_NUL);
         else if (c == MARK_ONES) msg_bytes.push_back(8'hFF);
         else msg_bytes.push_back(c);
      end
   endfunction

   // One byte: optional gap, hold valid until accepted, then update the prediction
   task automatic send_byte(input logic [7:0] ch, input logic last, input bit typed,
                            input nvcp_pkg::rsp_type fixed);
      nvcp_pkg::req_type item;
      nvcp_pkg::rsp_type predicted;
      int                gap;
      item.rx_byte        = ch;
      item.end_of_message = last;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (advance_parse(item, predicted)) predicted_results.push_back(typed ? fixed : predicted);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input bit typed, input nvcp_pkg::rsp_type fixed);
      for (int i = 0; i < msg_bytes.size(); i++)
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1, typed, fixed);
   endtask

   // Register write only once the parser has drained
   task automatic write_csr(input logic [nvcp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] data);
      req_valid <= 1'b0;
      while (predicted_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic randomize_names();
      write_csr(nvcp_pkg::CSR_NAME_COUNT, 64'($urandom_range(0, 7)));
      for (int s = 0; s < NAME_SLOTS; s++)
         write_csr(nvcp_pkg::CSR_NAME_0 + 3'(s), random_name());
      if ($urandom_range(0, 3) == 0)
         write_csr(3'($urandom_range(CSR_SPARE, CSR_INDEX_TOP)), {$urandom, $urandom});
   endtask

   task automatic push_digits(input int n);
      repeat (n) msg_bytes.push_back(nvcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
   endtask

   // Mostly well-formed name=value messages, some noise and broken ones
   task automatic build_random_message();
      logic [63:0] eff;
      int          r;
      msg_bytes.delete();
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      // name part
      r = $urandom_range(0, 99);
      if (r < 70) begin
         eff = effective_name(cfg_names[$urandom_range(0, NAME_SLOTS - 1)]);
         for (int i = 0; i < 8; i++)
            if (eff[8*i +: 8] != nvcp_pkg::CH_NUL) msg_bytes.push_back(eff[8*i +: 8]);
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom_range(33, 126)));
      end else if (r >= 80) begin
         repeat ($urandom_range(1, 11)) msg_bytes.push_back(8'($urandom_range(33, 126)));
      end
      if ($urandom_range(0, 19) == 0) msg_bytes.push_back(nvcp_pkg::CH_NUL);
      // value part, occasionally left out
      if ($urandom_range(0, 19) != 0) begin
         msg_bytes.push_back(nvcp_pkg::CH_EQUALS);
         r = $urandom_range(0, 99);
         if (r < 30) msg_bytes.push_back(nvcp_pkg::CH_MINUS);
         else if (r < 45) msg_bytes.push_back(nvcp_pkg::CH_PLUS);
         push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4));
         if ($urandom_range(0, 1) == 1) begin
            msg_bytes.push_back(nvcp_pkg::CH_POINT);
            push_digits($urandom_range(0, 12));
         end
         if ($urandom_range(0, 9) == 0) begin
            msg_bytes.push_back(8'($urandom_range(1, 255)));
            push_digits($urandom_range(0, 3));
         end
         r = $urandom_range(0, 99);
         if (r < 40) msg_bytes.push_back(nvcp_pkg::CH_HASH);
         else if (r < 50) msg_bytes.push_back(nvcp_pkg::CH_NUL);
         if (r < 50 && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 5)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (msg_bytes.size() == 0) msg_bytes.push_back(nvcp_pkg::CH_HASH);
   endtask

   // Result side: random stalls, calm stretches, and one long hold on request
   initial begin
      int hold_left;
      int gap_left;
      int stretch;
      bit calm;
      bit hold_taken;
      hold_left  = 0;
      gap_left   = 0;
      stretch    = 0;
      calm       = 1'b0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         @(negedge clock);
         if (++stretch == 200) begin
            stretch = 0;
            calm    = ($urandom_range(0, 3) == 0);
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (gap_left > 0) begin
            rsp_ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_ready <= 1'b1;
            gap_left = pick_gap(calm);
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      nvcp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_results.size() == 0) begin
            $error("result item with none expected: matched %0d index %0d value %0d",
                   rsp_data.matched, rsp_data.match_index, rsp_data.parsed_value);
            errors++;
         end else begin
            want = predicted_results.pop_front();
            if (rsp_data.matched !== want.matched) begin
               $error("matched: expected %0d, got %0d", want.matched, rsp_data.matched);
               errors++;
            end
            if (rsp_data.match_index !== want.match_index) begin
               $error("match_index: expected %0d, got %0d",
                      want.match_index, rsp_data.match_index);
               errors++;
            end
            if (rsp_data.parsed_value !== want.parsed_value) begin
               $error("parsed_value: expected %0d, got %0d",
                      want.parsed_value, rsp_data.parsed_value);
               errors++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("[name_value_command_parser] ERROR");
         $finish;
      end
   end

   // Main sequence
   initial begin
      int phase_start;
      cfg_count = '0;
      for (int s = 0; s < NAME_SLOTS; s++) cfg_names[s] = '0;
      clear_message();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed script; ~ is a NUL byte, ^ is 0xFF
      add_checked("=5", 1'b0, 2'd0, 48'sd0);               // no names after reset
      add_csr(nvcp_pkg::CSR_NAME_COUNT, 64'd4);
      add_csr(nvcp_pkg::CSR_NAME_0, pack_name("spd"));
      add_csr(nvcp_pkg::CSR_NAME_0 + 3'd1, pack_name("kp"));
      add_csr(nvcp_pkg::CSR_NAME_0 + 3'd2, 64'hFFFF_FFFF_FFFF_FFFF);
      add_csr(CSR_NAME_LAST, 64'd0);
      add_msg("spd=12.5#");
      add_checked("kp=-3#", 1'b1, 2'd1, -48'sd196608);
      add_msg("spd=+7");
      add_checked("spd=2147483647#", 1'b1, 2'd0, 48'sh7FFF_FFFF_0000);
      add_checked("spd=99999999999#", 1'b1, 2'd0, 48'sh7FFF_FFFF_0000);  // saturates
      add_msg("kp=0.999999999999#");
      add_checked("spd=-#", 1'b1, 2'd0, 48'sd0);
      add_checked("spd=abc", 1'b1, 2'd0, 48'sd0);
      add_msg("spd=1.2.3x9");
      add_msg("spd=12~99");
      add_checked("~spd=5", 1'b0, 2'd0, 48'sd0);            // rejected
      add_checked("spd5", 1'b0, 2'd0, 48'sd0);              // no equals sign
      add_checked("^^^^^^^^^^=1", 1'b1, 2'd2, 48'sd65536);  // long name cut to 8
      add_checked("spdxxxxxyyy=4", 1'b0, 2'd0, 48'sd0);
      add_checked("=8#", 1'b1, 2'd3, 48'sd524288);          // empty name, zero entry
      add_checked("spd==3", 1'b1, 2'd0, 48'sd0);
      add_msg("spd=3#junk");
      add_checked("kp=--1", 1'b1, 2'd1, 48'sd0);
      add_msg("kp=-0.0625");
      add_csr(nvcp_pkg::CSR_NAME_COUNT, 64'd7);
      add_csr(nvcp_pkg::CSR_NAME_0, pack_name("kp") | 64'h4142_0000_0000_0000);
      add_checked("kp=1#", 1'b1, 2'd0, 48'sd65536);        // first match wins
      add_csr(nvcp_pkg::CSR_NAME_COUNT, 64'd1);
      add_csr(CSR_INDEX_TOP, 64'd0);
      add_checked("=8", 1'b0, 2'd0, 48'sd0);

      for (int i = 0; i < script.size(); i++) begin
         if (script[i].kind == ROW_CSR) write_csr(script[i].csr_index, script[i].csr_data);
         else begin
            load_text(script_text[i]);
            send_message(script[i].typed, script[i].reply);
         end
      end

      // Random phases, each under fresh name settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         randomize_names();
         if (p == 2) begin
            sender_calm  = 1'b1;
            hold_request = 1'b1;
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_random_message();
            send_message(1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (predicted_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) $display("[name_value_command_parser] OK");
      else $display("[name_value_command_parser] ERROR");
      $finish;
   end

endmodule
